/* design/slcfp_pkg.sv */
// ----------------------------------------------------------------------------
// slcfp_pkg
// shared types and constants of the sync / length / checksum frame parser
// ----------------------------------------------------------------------------
package slcfp_pkg;

	localparam int unsigned BYTE_W = 8;

	// sync byte value after reset
	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

	// parse phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_SYNC2 = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_CSUM  = 5'b10000
	} phase_t;

	// one result request
	typedef struct packed {
		logic              payload_valid;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] packet_length;
		logic              packet_done;
		logic              checksum_ok;
	} result_t;

endpackage

/* design/slcfp_if.sv */
// ----------------------------------------------------------------------------
// slcfp channels
// valid / ready channels for received bytes and for parse results
// ----------------------------------------------------------------------------
interface slcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfp_result_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] packet_length;
	logic       packet_done;
	logic       checksum_ok;

	modport source (
		output valid, output payload_valid, output payload_byte, output payload_index,
		output packet_length, output packet_done, output checksum_ok, input ready
	);
	modport sink (
		input valid, input payload_valid, input payload_byte, input payload_index,
		input packet_length, input packet_done, input checksum_ok, output ready
	);
endinterface

/* design/slcfp_deframer.sv */
// ----------------------------------------------------------------------------
// slcfp_deframer
// parse state and the per-byte step: hunt, sync, length, payload, checksum
// ----------------------------------------------------------------------------
module slcfp_deframer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             sync_value,
	output slcfp_pkg::result_t     res
);
	import slcfp_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] left_q, left_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] idx_q, idx_d;
	logic [BYTE_W-1:0] len_q, len_d;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		sum_d   = sum_q;
		idx_d   = idx_q;
		len_d   = len_q;
		res     = '0;
		case (phase_q)
			PH_SYNC2: begin
				phase_d = (rx_byte == sync_value) ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				left_d  = rx_byte;
				sum_d   = rx_byte;
				idx_d   = '0;
				phase_d = (rx_byte == '0) ? PH_CSUM : PH_DATA;
			end
			PH_DATA: begin
				sum_d             = sum_q + rx_byte;
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = idx_q;
				idx_d             = idx_q + 8'd1;
				left_d            = left_q - 8'd1;
				phase_d           = (left_d == '0) ? PH_CSUM : PH_DATA;
			end
			PH_CSUM: begin
				res.packet_done = 1'b1;
				res.checksum_ok = (rx_byte == sum_q);
				phase_d         = PH_HUNT;
			end
			default: begin
				phase_d = (rx_byte == sync_value) ? PH_SYNC2 : PH_HUNT;
				sum_d   = '0;
			end
		endcase
		// length after this byte
		res.packet_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			left_q  <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			len_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
		end
	end

endmodule

/* design/sync_length_checksum_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser_top
// deframes sync, sync, length, payload, checksum packets from a byte stream
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  rx        in   valid/ready    rx_byte
//  result    out  valid/ready    payload_valid, payload_byte, payload_index,
//                                packet_length, packet_done, checksum_ok
//  cfg       in   cfg_we only    cfg_wdata = sync_value
//
//  one result request per byte request, one byte per cycle unless result stalls
//  a byte passes the input register, then the parse step into the result register
//  the parse state loop updates in the cycle a byte leaves the input register
//  arst_n clears the parse state to the hunt and sync_value to 0xaa
//  a stalled result register still lets the input register fill; rx.ready
//  drops only when both hold a request
//
module sync_length_checksum_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	slcfp_byte_if.sink     rx,
	slcfp_result_if.source result,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import slcfp_pkg::*;

	// sync byte register
	logic [BYTE_W-1:0] sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// input register
	logic              byte_valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	// result register
	logic              res_valid_s2;
	result_t           res_s2;
	result_t           res_step;
	logic              advance;

	// byte moves into the result register when that one is free or being drained
	assign advance  = byte_valid_s1 && (!res_valid_s2 || result.ready);
	assign rx.ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			byte_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// parse step, state advances only when the byte is consumed
	slcfp_deframer u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.sync_value (sync_q),
		.res        (res_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_step;
		end
	end

	assign result.valid         = res_valid_s2;
	assign result.payload_valid = res_s2.payload_valid;
	assign result.payload_byte  = res_s2.payload_byte;
	assign result.payload_index = res_s2.payload_index;
	assign result.packet_length = res_s2.packet_length;
	assign result.packet_done   = res_s2.packet_done;
	assign result.checksum_ok   = res_s2.checksum_ok;

`ifndef SYNTH
	// a payload byte never also closes a packet
	a_payload_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.payload_valid && result.packet_done))
		else $error("payload and packet end in one result");

	// checksum status only on a packet end
	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.checksum_ok) |-> result.packet_done)
		else $error("checksum_ok without packet_done");

	// an accepted byte is held in the input register next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready) |=> byte_valid_s1)
		else $error("accepted byte lost");

	// a byte consumed by the step always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_s2)
		else $error("parse step result lost");
`endif

endmodule
